/* design/console_line_editor_assert.svh */
`ifndef CONSOLE_LINE_EDITOR_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CLE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("console_line_editor port check failed");

// next-cycle implication, checked outside reset
`define CLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("console_line_editor port check failed");

`endif

/* design/cle_pkg.sv */
package cle_pkg;

   localparam int unsigned RSP_DATA_W = 16;

   // result channels
   localparam logic [1:0] CH_ECHO   = 2'd0;
   localparam logic [1:0] CH_LINE   = 2'd1;
   localparam logic [1:0] CH_STATUS = 2'd2;

   // status codes
   localparam logic [7:0] ST_COMPLETE = 8'd0;
   localparam logic [7:0] ST_CANCEL   = 8'd1;
   localparam logic [7:0] ST_TIMEOUT  = 8'd2;

   // request kinds
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // configuration register indexes
   localparam logic CSR_ECHO_ENABLE   = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   // characters
   localparam logic [7:0] CHR_CTRL_C    = 8'h03;
   localparam logic [7:0] CHR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHR_LF        = 8'h0A;
   localparam logic [7:0] CHR_CTRL_K    = 8'h0B;
   localparam logic [7:0] CHR_CR        = 8'h0D;
   localparam logic [7:0] CHR_CTRL_U    = 8'h15;
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] CHR_CARET     = 8'h5E;
   localparam logic [7:0] CHR_UPPER_C   = 8'h43;
   localparam logic [7:0] CHR_TILDE     = 8'h7E;

   typedef struct packed {
      logic store_wr;
      logic fill_dec;
      logic line_clear;
      logic tick;
   } cmd_type;

   typedef struct packed {
      logic fill_zero;
      logic full;
      logic timeout_hit;
      logic echo_en;
   } sts_type;

endpackage

/* design/console_line_editor.sv */
// channel  direction  handshake                 payload
// req      in         req_tvalid / req_tready   tuser command, tdata rx_byte
// rsp      out        rsp_tvalid / rsp_tready   tuser channel, tdata char/length, tlast
// csr      in         csr_valid / csr_ready     csr_index, csr_data
//
// one request at a time; once taken, the result sequencer issues its results while
// rsp_tready is high (line kill: echoed backspace, space, backspace per erased
// character; completion: echoed LF, line characters, status; tick: timeout status)
// results leave through one output register, so the next request is taken while the
// last result still waits; csr_ready is always high
// synchronous active-high reset empties the line, clears the tick count, echo on
module console_line_editor #(
   parameter int BUF_SIZE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] char_value, [11:8] line_length
   output logic [1:0]  rsp_tuser,   // [1:0] channel
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import cle_pkg::*;

   localparam int CNT_W = $clog2(BUF_SIZE);

   cmd_type          cmd;
   sts_type          sts;
   logic [7:0]       wr_data;
   logic [CNT_W-1:0] rd_idx;
   logic [7:0]       rd_data;
   logic [CNT_W-1:0] fill;

   assign csr_ready = 1'b1;

   cle_control #(
      .CNT_W(CNT_W)
   ) u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts),
      .wr_data    (wr_data),
      .rd_idx     (rd_idx),
      .rd_data    (rd_data),
      .fill       (fill)
   );

   cle_datapath #(
      .BUF_SIZE(BUF_SIZE),
      .CNT_W   (CNT_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .wr_data   (wr_data),
      .rd_idx    (rd_idx),
      .rd_data   (rd_data),
      .fill      (fill),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

/* design/cle_datapath.sv */
module cle_datapath #(
   parameter int BUF_SIZE = 16,
   parameter int CNT_W    = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  cle_pkg::cmd_type cmd,
   output cle_pkg::sts_type sts,
   input  logic [7:0]       wr_data,
   input  logic [CNT_W-1:0] rd_idx,
   output logic [7:0]       rd_data,
   output logic [CNT_W-1:0] fill,
   input  logic             csr_valid,
   input  logic             csr_index,
   input  logic [31:0]      csr_data
);
   import cle_pkg::*;

   logic [7:0]       store_ff [BUF_SIZE];
   logic [7:0]       rd_data_ff;
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic [31:0]      elapsed_ff;
   logic [31:0]      elapsed_in;
   logic             echo_ff;
   logic [31:0]      timeout_ff;

   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         store_ff[fill_ff] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_idx];
   end

   always_comb begin
      fill_in = fill_ff;
      priority if (cmd.line_clear) begin
         fill_in = '0;
      end else if (cmd.store_wr) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.fill_dec) begin
         fill_in = fill_ff - 1'b1;
      end else begin
         fill_in = fill_ff;
      end
      elapsed_in = elapsed_ff;
      priority if (cmd.line_clear) begin
         elapsed_in = '0;
      end else if (cmd.tick && (elapsed_ff != '1)) begin
         elapsed_in = elapsed_ff + 32'd1;
      end else begin
         elapsed_in = elapsed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         elapsed_ff <= '0;
         echo_ff    <= 1'b1;
         timeout_ff <= '0;
      end else begin
         fill_ff    <= fill_in;
         elapsed_ff <= elapsed_in;
         if (csr_valid && (csr_index == CSR_ECHO_ENABLE)) begin
            echo_ff <= csr_data[0];
         end
         if (csr_valid && (csr_index == CSR_TIMEOUT_TICKS)) begin
            timeout_ff <= csr_data;
         end
      end
   end

   assign rd_data         = rd_data_ff;
   assign fill            = fill_ff;
   assign sts.fill_zero   = (fill_ff == '0);
   assign sts.full        = (fill_ff == CNT_W'(BUF_SIZE - 1));
   assign sts.timeout_hit = (timeout_ff != '0) && (elapsed_ff > timeout_ff);
   assign sts.echo_en     = echo_ff;

endmodule

/* design/cle_control.sv */
module cle_control #(
   parameter int CNT_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic [0:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   output cle_pkg::cmd_type cmd,
   input  cle_pkg::sts_type sts,
   output logic [7:0]       wr_data,
   output logic [CNT_W-1:0] rd_idx,
   input  logic [7:0]       rd_data,
   input  logic [CNT_W-1:0] fill
);
   import cle_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK,
      S_ERASE,
      S_CANCEL,
      S_NEWLINE,
      S_LINE,
      S_DONE,
      S_PRINT
   } state_type;

   localparam int EXT_W = (CNT_W > 4) ? CNT_W : 4;

   state_type        state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       byte_ff, byte_in;
   logic             kill_ff, kill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_val_ff;
   logic [3:0]       rsp_len_ff;
   logic [1:0]       rsp_ch_ff;
   logic             rsp_last_ff;

   logic             slot_free, emit, go;
   logic [1:0]       out_ch;
   logic [7:0]       out_val;
   logic [3:0]       out_len;
   logic             out_last;
   logic [EXT_W-1:0] fill_ext;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign go        = !emit || slot_free;
   assign fill_ext  = EXT_W'(fill);

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      byte_in    = byte_ff;
      kill_in    = kill_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      emit       = 1'b0;
      out_ch     = CH_ECHO;
      out_val    = '0;
      out_len    = '0;
      out_last   = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            phase_in   = '0;
            idx_in     = '0;
            if (req_tvalid) begin
               if (req_tuser[0] == CMD_TICK) begin
                  cmd.tick = 1'b1;
                  state_in = S_TICK;
               end else begin
                  priority if (req_tdata == CHR_BACKSPACE) begin
                     if (!sts.fill_zero) begin
                        cmd.fill_dec = 1'b1;
                        kill_in      = 1'b0;
                        state_in     = S_ERASE;
                     end
                  end else if (req_tdata == CHR_CTRL_C) begin
                     state_in = S_CANCEL;
                  end else if ((req_tdata == CHR_CTRL_K) || (req_tdata == CHR_CTRL_U)) begin
                     if (!sts.fill_zero) begin
                        cmd.fill_dec = 1'b1;
                        kill_in      = 1'b1;
                        state_in     = S_ERASE;
                     end
                  end else if ((req_tdata == CHR_CR) || (req_tdata == CHR_LF)) begin
                     state_in = S_NEWLINE;
                  end else if ((req_tdata >= CHR_SPACE) && (req_tdata <= CHR_TILDE)) begin
                     if (!sts.full) begin
                        cmd.store_wr = 1'b1;
                        byte_in      = req_tdata;
                        state_in     = S_PRINT;
                     end
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_TICK: begin
            emit     = sts.timeout_hit;
            out_ch   = CH_STATUS;
            out_val  = ST_TIMEOUT;
            out_last = 1'b1;
            if (go) begin
               cmd.line_clear = emit;
               state_in       = S_IDLE;
            end
         end
         S_ERASE: begin
            emit     = sts.echo_en;
            out_val  = (phase_ff == 2'd1) ? CHR_SPACE : CHR_BACKSPACE;
            out_last = (phase_ff == 2'd2) && (!kill_ff || sts.fill_zero);
            if (go) begin
               if (phase_ff == 2'd2) begin
                  phase_in = '0;
                  if (kill_ff && !sts.fill_zero) begin
                     cmd.fill_dec = 1'b1;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         S_CANCEL: begin
            unique case (phase_ff)
               2'd0: out_val = CHR_CARET;
               2'd1: out_val = CHR_UPPER_C;
               2'd2: out_val = CHR_LF;
               default: begin
                  out_ch   = CH_STATUS;
                  out_val  = ST_CANCEL;
                  out_last = 1'b1;
               end
            endcase
            emit = (phase_ff == 2'd3) || sts.echo_en;
            if (go) begin
               phase_in = phase_ff + 2'd1;
               if (phase_ff == 2'd3) begin
                  cmd.line_clear = 1'b1;
                  state_in       = S_IDLE;
               end
            end
         end
         S_NEWLINE: begin
            emit    = sts.echo_en;
            out_val = CHR_LF;
            if (go) begin
               state_in = sts.fill_zero ? S_DONE : S_LINE;
            end
         end
         S_LINE: begin
            emit    = 1'b1;
            out_ch  = CH_LINE;
            out_val = rd_data;
            if (go) begin
               if ((idx_ff + 1'b1) == fill) begin
                  state_in = S_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            emit     = 1'b1;
            out_ch   = CH_STATUS;
            out_val  = ST_COMPLETE;
            out_len  = fill_ext[3:0];
            out_last = 1'b1;
            if (go) begin
               cmd.line_clear = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_PRINT: begin
            emit     = sts.echo_en;
            out_val  = byte_ff;
            out_last = 1'b1;
            if (go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         byte_ff  <= byte_in;
         kill_ff  <= kill_in;
         idx_ff   <= idx_in;
         if (emit && slot_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_ch_ff    <= out_ch;
            rsp_val_ff   <= out_val;
            rsp_len_ff   <= out_len;
            rsp_last_ff  <= out_last;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // store read is registered, so address it with the next index
   assign wr_data    = req_tdata;
   assign rd_idx     = idx_in;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_len_ff, rsp_val_ff};
   assign rsp_tuser  = rsp_ch_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* design/cle_checker.sv */
`include "console_line_editor_assert.svh"

module cle_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import cle_pkg::*;

   logic        rsp_stall;
   logic        rsp_status;
   logic        rsp_complete;
   logic [18:0] rsp_bits;

   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign rsp_status   = rsp_tvalid && (rsp_tuser == CH_STATUS);
   assign rsp_complete = rsp_status && (rsp_tdata[7:0] == ST_COMPLETE);
   assign rsp_bits     = {rsp_tlast, rsp_tuser, rsp_tdata};

   // stalled result holds
   `CLE_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_bits))
   // a report always closes the request
   `CLE_ASSERT_NOW(a_status_last, rsp_status, rsp_tlast)
   // length only rides on a completion report
   `CLE_ASSERT_NOW(a_len_only_complete, rsp_tvalid && !rsp_complete, rsp_tdata[11:8] == 4'd0)
   // line characters are never the final result
   `CLE_ASSERT_NOW(a_line_not_last, rsp_tvalid && (rsp_tuser == CH_LINE), !rsp_tlast)

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);
